// ----- sv/psdq_pkg.sv -----
// Package for the per-slot datagram queue: shared constants, codes and types.
// No dependencies.
package psdq_pkg;
    localparam int SLOT_COUNT_DEF = 16;
    localparam int RING_DEPTH_DEF = 8;
    localparam int MAX_BYTES_DEF  = 512;
    // wide enough for a payload word address at the largest slot count,
    // ring depth and entry size
    localparam int ADDR_W         = 20;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADSLOT = 3'd1,
        ST_TOOLONG = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_NOOPEN  = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]        status;
        logic              is_read;
        logic [63:0]       ip_hi;
        logic [63:0]       ip_lo;
        logic [15:0]       port;
        logic [9:0]        len;
        logic [ADDR_W-1:0] base;
    } t_job;
endpackage

// ----- sv/psdq_front.sv -----
// Front part: accepts commands, keeps ring pointers and entry headers,
// writes payload words. Depends on psdq_pkg.
module psdq_front #(
    parameter int SLOT_COUNT = psdq_pkg::SLOT_COUNT_DEF,
    parameter int RING_DEPTH = psdq_pkg::RING_DEPTH_DEF,
    parameter int MAX_BYTES  = psdq_pkg::MAX_BYTES_DEF,
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int CW = $clog2(RING_DEPTH + 1),
    localparam int WPE = (MAX_BYTES + 7) / 8,
    localparam int ENT = SLOT_COUNT * RING_DEPTH,
    localparam int EW = (ENT > 1) ? $clog2(ENT) : 1,
    localparam int MD = ENT * WPE,
    localparam int MW = (MD > 1) ? $clog2(MD) : 1,
    localparam int AW = psdq_pkg::ADDR_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_slot,
    input  logic [63:0]        i_src_ip_hi,
    input  logic [63:0]        i_src_ip_lo,
    input  logic [15:0]        i_src_port,
    input  logic [15:0]        i_length,
    input  logic [15:0]        i_max_len,
    input  logic [63:0]        i_data_word,
    output logic               o_wr_en,
    output logic [MW-1:0]      o_wr_addr,
    output logic [63:0]        o_wr_data,
    output logic               o_job_valid,
    output psdq_pkg::t_job     o_job,
    input  logic               i_job_ready,
    input  logic               i_back_busy
);
    logic [RW-1:0] r_head [SLOT_COUNT];
    logic [RW-1:0] r_tail [SLOT_COUNT];
    logic [CW-1:0] r_cnt  [SLOT_COUNT];
    logic [63:0] r_eh [ENT];
    logic [63:0] r_el [ENT];
    logic [15:0] r_ep [ENT];
    logic [9:0]  r_elen [ENT];
    logic          r_open;
    logic [SW-1:0] r_oslot;
    logic [9:0]    r_left;
    logic [6:0]    r_widx;

    // stage 1: command result and popped entry index registered
    logic          r_s1_v;
    psdq_pkg::t_job r_s1;
    logic [15:0]   r_s1_max;
    logic [EW-1:0] r_s1_e;

    logic          bad;
    logic [SW-1:0] s;
    logic          fire;
    logic [EW-1:0] e_tail, e_head, e_open;
    logic [RW-1:0] ntail, nhead;
    logic          s2_free;
    logic          rd_busy;

    // hold input while a read is in flight so payload writes never overtake it
    assign rd_busy = (r_s1_v && r_s1.is_read) || (o_job_valid && o_job.is_read)
                     || i_back_busy;
    assign s2_free = !o_job_valid || i_job_ready;
    assign o_ready = (!r_s1_v || s2_free) && !rd_busy;
    assign fire = i_valid && o_ready;
    assign bad = ({8'd0, i_slot} >= 16'(SLOT_COUNT));
    assign s = i_slot[SW-1:0];
    assign e_tail = EW'(s * RING_DEPTH + int'(r_tail[s]));
    assign e_head = EW'(s * RING_DEPTH + int'(r_head[s]));
    assign e_open = EW'(r_oslot * RING_DEPTH + int'(r_tail[r_oslot]));
    assign ntail = (int'(r_tail[s]) == RING_DEPTH - 1) ? '0 : r_tail[s] + RW'(1);
    assign nhead = (int'(r_head[s]) == RING_DEPTH - 1) ? '0 : r_head[s] + RW'(1);

    logic [RW-1:0] otail_n;
    assign otail_n = (int'(r_tail[r_oslot]) == RING_DEPTH - 1) ? '0
                   : r_tail[r_oslot] + RW'(1);

    assign o_wr_en   = fire && i_command == psdq_pkg::CMD_DATA && r_open
                       && int'(r_widx) < WPE;
    assign o_wr_addr = MW'(int'(e_open) * WPE + int'(r_widx));
    assign o_wr_data = i_data_word;

    always_ff @(posedge i_clk) begin
        if (fire && i_command == psdq_pkg::CMD_START && !bad
            && i_length <= 16'(MAX_BYTES) && int'(r_cnt[s]) < RING_DEPTH) begin
            r_eh[e_tail] <= i_src_ip_hi;
            r_el[e_tail] <= i_src_ip_lo;
            r_ep[e_tail] <= i_src_port;
            r_elen[e_tail] <= i_length[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k]  <= '0;
            end
            r_open <= 1'b0;
            r_oslot <= '0;
            r_left <= '0;
            r_widx <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (s2_free) r_s1_v <= 1'b0;
            if (fire) begin
                r_s1_v <= 1'b1;
                r_s1 <= '0;
                r_s1.status <= psdq_pkg::ST_OK;
                r_s1_max <= i_max_len;
                r_s1_e <= e_head;
                unique case (psdq_pkg::t_cmd'(i_command))
                    psdq_pkg::CMD_START: begin
                        r_open <= 1'b0;
                        if (bad) r_s1.status <= psdq_pkg::ST_BADSLOT;
                        else if (i_length > 16'(MAX_BYTES))
                            r_s1.status <= psdq_pkg::ST_TOOLONG;
                        else if (int'(r_cnt[s]) >= RING_DEPTH)
                            r_s1.status <= psdq_pkg::ST_FULL;
                        else begin
                            r_oslot <= s;
                            r_left <= i_length[9:0];
                            r_widx <= '0;
                            if (i_length == 16'd0) begin
                                r_tail[s] <= ntail;
                                r_cnt[s] <= r_cnt[s] + CW'(1);
                            end else r_open <= 1'b1;
                        end
                    end
                    psdq_pkg::CMD_DATA: begin
                        if (!r_open) r_s1.status <= psdq_pkg::ST_NOOPEN;
                        else begin
                            r_widx <= r_widx + 7'd1;
                            if (r_left > 10'd8) r_left <= r_left - 10'd8;
                            else begin
                                r_left <= '0;
                                r_tail[r_oslot] <= otail_n;
                                r_cnt[r_oslot] <= r_cnt[r_oslot] + CW'(1);
                                r_open <= 1'b0;
                            end
                        end
                    end
                    psdq_pkg::CMD_READ: begin
                        if (bad) r_s1.status <= psdq_pkg::ST_BADSLOT;
                        else if (r_cnt[s] == '0) r_s1.status <= psdq_pkg::ST_EMPTY;
                        else begin
                            r_s1.is_read <= 1'b1;
                            r_head[s] <= nhead;
                            r_cnt[s] <= r_cnt[s] - CW'(1);
                        end
                    end
                    psdq_pkg::CMD_QUERY: begin
                        if (bad) r_s1.status <= psdq_pkg::ST_BADSLOT;
                        else r_s1.len <= 10'(r_cnt[s]);
                    end
                    default: ;
                endcase
            end
        end
    end

    // stage 2: fetch header of popped entry, clip length
    logic [9:0] elen;
    assign elen = r_elen[r_s1_e];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_job_valid <= 1'b0;
        end else if (s2_free) begin
            o_job_valid <= r_s1_v;
            o_job <= r_s1;
            if (r_s1.is_read) begin
                o_job.ip_hi <= r_eh[r_s1_e];
                o_job.ip_lo <= r_el[r_s1_e];
                o_job.port  <= r_ep[r_s1_e];
                o_job.len   <= ({6'd0, elen} > r_s1_max) ? r_s1_max[9:0] : elen;
                o_job.base  <= AW'(int'(r_s1_e) * WPE);
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt[s]) <= RING_DEPTH) else $error("ring count overflow");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> r_open) else $error("write without open deposit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid) else $error("job dropped");
`endif
endmodule

// ----- sv/psdq_back.sv -----
// Back part: payload memory and result streaming with output queue.
// Depends on psdq_pkg.
module psdq_back #(
    parameter int SLOT_COUNT = psdq_pkg::SLOT_COUNT_DEF,
    parameter int RING_DEPTH = psdq_pkg::RING_DEPTH_DEF,
    parameter int MAX_BYTES  = psdq_pkg::MAX_BYTES_DEF,
    localparam int WPE = (MAX_BYTES + 7) / 8,
    localparam int MD = SLOT_COUNT * RING_DEPTH * WPE,
    localparam int MW = (MD > 1) ? $clog2(MD) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [MW-1:0]      i_wr_addr,
    input  logic [63:0]        i_wr_data,
    input  logic               i_job_valid,
    input  psdq_pkg::t_job     i_job,
    output logic               o_job_ready,
    output logic               o_busy,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [2:0]         o_status,
    output logic [63:0]        o_src_ip_hi_res,
    output logic [63:0]        o_src_ip_lo_res,
    output logic [15:0]        o_src_port_res,
    output logic [9:0]         o_length_res,
    output logic [63:0]        o_data_word_res,
    output logic [3:0]         o_data_bytes,
    output logic               o_last
);
    logic [63:0] r_mem [MD];
    logic        r_busy;
    psdq_pkg::t_job r_job;
    logic [6:0]  r_w;
    logic [9:0]  r_rem;
    // read pipe stage
    logic        r_p_v;
    logic [63:0] r_p_data;
    logic [3:0]  r_p_nb;
    logic        r_p_last;
    logic        r_p_mem;
    psdq_pkg::t_job r_p_job;
    // output register
    logic        r_o_v;

    logic o_free, p_free, issue;
    assign o_free = !r_o_v || i_pop;
    assign p_free = !r_p_v || o_free;
    assign issue  = r_busy && p_free;
    assign o_job_ready = !r_busy && p_free;
    assign o_busy = r_busy;
    assign o_empty = !r_o_v;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (issue) r_p_data <= r_mem[MW'(r_job.base) + MW'(r_w)];
    end

    logic [63:0] mask;
    always_comb begin
        mask = '0;
        for (int b = 0; b < 8; b++)
            if (4'(b) < r_p_nb) mask[b*8 +: 8] = 8'hFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (o_free) begin
                r_o_v <= r_p_v;
                if (r_p_v) begin
                    o_status <= r_p_job.status;
                    o_src_ip_hi_res <= r_p_job.ip_hi;
                    o_src_ip_lo_res <= r_p_job.ip_lo;
                    o_src_port_res <= r_p_job.port;
                    o_length_res <= r_p_job.len;
                    o_data_word_res <= r_p_mem ? (r_p_data & mask) : 64'd0;
                    o_data_bytes <= r_p_mem ? r_p_nb : 4'd0;
                    o_last <= r_p_last;
                end
            end
            if (p_free) r_p_v <= 1'b0;
            if (o_job_ready && i_job_valid) begin
                if (i_job.is_read && i_job.len != 10'd0) begin
                    r_busy <= 1'b1;
                    r_job <= i_job;
                    r_w <= '0;
                    r_rem <= i_job.len;
                end else begin
                    r_p_v <= 1'b1;
                    r_p_job <= i_job;
                    r_p_mem <= 1'b0;
                    r_p_nb <= '0;
                    r_p_last <= 1'b1;
                end
            end
            if (issue) begin
                // advance one payload word per cycle while the read pipe stage is free
                r_p_v <= 1'b1;
                r_p_job <= r_job;
                r_p_mem <= 1'b1;
                r_p_nb <= (r_rem > 10'd8) ? 4'd8 : r_rem[3:0];
                r_p_last <= (r_rem <= 10'd8);
                r_w <= r_w + 7'd1;
                r_rem <= (r_rem > 10'd8) ? r_rem - 10'd8 : 10'd0;
                if (r_rem <= 10'd8) r_busy <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_nb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> o_data_bytes <= 4'd8) else $error("byte count range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem != 10'd0) else $error("idle stream busy");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && !i_pop |=> r_o_v && $stable(o_data_word_res))
        else $error("result changed while waiting");
`endif
endmodule

// ----- sv/per_slot_datagram_queue.sv -----
// Top level of the per-slot datagram queue: front and back parts.
// Depends on psdq_pkg, psdq_front, psdq_back.
//
// Input channel: push/full with command, slot, address, port, length,
// max_len and data word. Result channel: empty/pop; each item gives one
// result, a successful read one result per 8-byte payload word with last
// set on the final one.
// The front part takes one item per cycle through its two header stages
// while the back part keeps up and no read holds the input. While a
// successful read is in flight (in those stages or streaming from the back
// part) hold full high, so payload writes never overtake the words being
// read. The back part streams one payload word per cycle while results are
// popped; the input stays closed until a read's last word is issued. Results
// pass stage 1, stage 2, the back read pipe stage and the output register.
// Reset clears ring pointers, counts and the open deposit; the entry and
// payload stores are not cleared and hold whatever was last written.
// When the receiver stalls, the result holds and full rises once at most
// four items wait inside the block.
module per_slot_datagram_queue #(
    parameter int SLOT_COUNT = psdq_pkg::SLOT_COUNT_DEF,
    parameter int RING_DEPTH = psdq_pkg::RING_DEPTH_DEF,
    parameter int MAX_DATAGRAM_BYTES = psdq_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_slot,
    input  logic [63:0] i_src_ip_hi,
    input  logic [63:0] i_src_ip_lo,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_length,
    input  logic [15:0] i_max_len,
    input  logic [63:0] i_data_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [63:0] o_src_ip_hi_res,
    output logic [63:0] o_src_ip_lo_res,
    output logic [15:0] o_src_port_res,
    output logic [9:0]  o_length_res,
    output logic [63:0] o_data_word_res,
    output logic [3:0]  o_data_bytes,
    output logic        o_last
);
    localparam int WPE = (MAX_DATAGRAM_BYTES + 7) / 8;
    localparam int MD  = SLOT_COUNT * RING_DEPTH * WPE;
    localparam int MW  = (MD > 1) ? $clog2(MD) : 1;

    logic           ready, wr_en, job_valid, job_ready, back_busy;
    logic [MW-1:0]  wr_addr;
    logic [63:0]    wr_data;
    psdq_pkg::t_job job;

    assign full = !ready;

    psdq_front #(
        .SLOT_COUNT(SLOT_COUNT), .RING_DEPTH(RING_DEPTH),
        .MAX_BYTES(MAX_DATAGRAM_BYTES)
    ) u_front (
        .i_clk, .i_rst_n, .i_valid(push), .o_ready(ready),
        .i_command, .i_slot, .i_src_ip_hi, .i_src_ip_lo, .i_src_port,
        .i_length, .i_max_len, .i_data_word,
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready),
        .i_back_busy(back_busy)
    );

    psdq_back #(
        .SLOT_COUNT(SLOT_COUNT), .RING_DEPTH(RING_DEPTH),
        .MAX_BYTES(MAX_DATAGRAM_BYTES)
    ) u_back (
        .i_clk, .i_rst_n, .i_wr_en(wr_en), .i_wr_addr(wr_addr),
        .i_wr_data(wr_data), .i_job_valid(job_valid), .i_job(job),
        .o_job_ready(job_ready), .o_busy(back_busy), .o_empty(empty), .i_pop(pop),
        .o_status, .o_src_ip_hi_res, .o_src_ip_lo_res, .o_src_port_res,
        .o_length_res, .o_data_word_res, .o_data_bytes, .o_last
    );
endmodule
